// ===== hw/rtl/weekly_alarm_earliest_finder_macros.svh =====
// assertion macros for the weekly alarm earliest finder
// used by the top level only, no other dependencies
`ifndef WEEKLY_ALARM_EARLIEST_FINDER_MACROS_SVH
`define WEEKLY_ALARM_EARLIEST_FINDER_MACROS_SVH

`ifndef SYNTH
`define WAEF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("weekly alarm finder check failed");
`define WAEF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("weekly alarm finder check failed");
`else
`define WAEF_ASSERT(label, clk, rst, prop)
`define WAEF_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hw/rtl/waef_pkg.sv =====
// shared widths, constants, types and time helpers of the alarm finder
// no dependencies
`timescale 1ns / 1ps

package waef_pkg;

  localparam int HOUR_W      = 5;
  localparam int MIN_W       = 6;
  localparam int WDAY_W      = 3;
  localparam int MASK_W      = 8;
  localparam int IDX_W       = 8;
  localparam int DELTA_W     = 14;
  localparam int TOD_W       = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;

  localparam int INDEX_BITS_DEFAULT = 8;

  localparam logic [HOUR_W-1:0]  MAX_HOUR      = 5'd23;
  localparam logic [MIN_W-1:0]   MAX_MINUTE    = 6'd59;
  localparam logic [WDAY_W-1:0]  LAST_WEEKDAY  = 3'd6;
  localparam logic [WDAY_W-1:0]  DAYS_IN_WEEK  = 3'd7;
  localparam logic [DELTA_W-1:0] DAY_MINUTES   = 14'd1440;
  localparam logic [DELTA_W-1:0] WEEK_MINUTES  = 14'd10080;
  localparam logic [TOD_W-1:0]   HOUR_MINUTES  = 11'd60;
  localparam int                 ONCE_BIT      = 7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WEEKDAY = 2'd0,
    CFG_HOUR    = 2'd1,
    CFG_MINUTE  = 2'd2
  } cfg_index_t;

  // per-entry evaluation handed to the running minimum
  typedef struct packed {
    logic                hit;
    logic [DELTA_W-1:0]  delta;
    logic [WDAY_W-1:0]   weekday;
    logic [HOUR_W-1:0]   hour;
    logic [MIN_W-1:0]    minute;
  } eval_t;

  // control of the registered entry stage
  typedef struct packed {
    logic valid;
    logic last;
  } stage_t;

  function automatic logic [HOUR_W-1:0] sat_hour(input logic [HOUR_W-1:0] h);
    return (h > MAX_HOUR) ? MAX_HOUR : h;
  endfunction

  function automatic logic [MIN_W-1:0] sat_minute(input logic [MIN_W-1:0] m);
    return (m > MAX_MINUTE) ? MAX_MINUTE : m;
  endfunction

  function automatic logic [TOD_W-1:0] time_of_day(input logic [HOUR_W-1:0] h,
                                                    input logic [MIN_W-1:0]  m);
    return TOD_W'(h) * HOUR_MINUTES + TOD_W'(m);
  endfunction

  // (a + b) mod 7 for a <= 6, b <= 7
  function automatic logic [WDAY_W-1:0] weekday_add(input logic [WDAY_W-1:0] a,
                                                     input logic [WDAY_W-1:0] b);
    logic [WDAY_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, DAYS_IN_WEEK}) begin
      sum = sum - {1'b0, DAYS_IN_WEEK};
    end
    return sum[WDAY_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/waef_entry_if.sv =====
// entry channel: valid/ready handshake with one alarm entry as payload
// depends on waef_pkg
`timescale 1ns / 1ps

interface waef_entry_if
  import waef_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [HOUR_W-1:0] entry_hour;
  logic [MIN_W-1:0]  entry_minute;
  logic [MASK_W-1:0] repeat_mask;
  logic              entry_active;
  logic              entry_valid;
  logic              entry_source;
  logic [IDX_W-1:0]  entry_index;
  logic              last_entry;

  modport source (
    output valid, entry_hour, entry_minute, repeat_mask, entry_active,
           entry_valid, entry_source, entry_index, last_entry,
    input  ready
  );

  modport sink (
    input  valid, entry_hour, entry_minute, repeat_mask, entry_active,
           entry_valid, entry_source, entry_index, last_entry,
    output ready
  );
endinterface

// ===== hw/rtl/waef_result_if.sv =====
// result channel: valid/ready handshake with the scan winner as payload
// depends on waef_pkg
`timescale 1ns / 1ps

interface waef_result_if
  import waef_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               found;
  logic               win_source;
  logic [IDX_W-1:0]   win_index;
  logic [WDAY_W-1:0]  next_weekday;
  logic [HOUR_W-1:0]  next_hour;
  logic [MIN_W-1:0]   next_minute;
  logic [DELTA_W-1:0] delta_minutes;

  modport source (
    output valid, found, win_source, win_index, next_weekday, next_hour,
           next_minute, delta_minutes,
    input  ready
  );

  modport sink (
    input  valid, found, win_source, win_index, next_weekday, next_hour,
           next_minute, delta_minutes,
    output ready
  );
endinterface

// ===== hw/rtl/waef_entry_eval.sv =====
// next firing day and minutes-ahead of one entry, purely combinational
// depends on waef_pkg
`timescale 1ns / 1ps

module waef_entry_eval
  import waef_pkg::*;
(
  input  logic [WDAY_W-1:0] now_weekday,
  input  logic [HOUR_W-1:0] now_hour,
  input  logic [MIN_W-1:0]  now_minute,
  input  logic [HOUR_W-1:0] entry_hour,
  input  logic [MIN_W-1:0]  entry_minute,
  input  logic [MASK_W-1:0] repeat_mask,
  input  logic              entry_active,
  input  logic              entry_valid,
  output eval_t             ev
);

  logic [WDAY_W-1:0] wd;
  logic [HOUR_W-1:0] eh;
  logic [MIN_W-1:0]  em;
  logic [TOD_W-1:0]  now_tod;
  logic [TOD_W-1:0]  tgt_tod;
  logic              ahead;
  logic [6:0]        rot;
  logic [WDAY_W-1:0] days;
  logic              ok;

  always_comb begin
    wd      = (now_weekday > LAST_WEEKDAY) ? '0 : now_weekday;
    eh      = sat_hour(entry_hour);
    em      = sat_minute(entry_minute);
    now_tod = time_of_day(sat_hour(now_hour), sat_minute(now_minute));
    tgt_tod = time_of_day(eh, em);
    ahead   = now_tod < tgt_tod;

    // weekday mask rotated so that bit 0 is today
    for (int k = 0; k < 7; k++) begin
      rot[k] = repeat_mask[weekday_add(wd, WDAY_W'(k))];
    end

    days = '0;
    ok   = 1'b0;
    if (repeat_mask[ONCE_BIT]) begin
      days = ahead ? WDAY_W'(0) : WDAY_W'(1);
      ok   = 1'b1;
    end else if (rot[0] && ahead) begin
      days = '0;
      ok   = 1'b1;
    end else begin
      // first masked day after today
      for (int k = 6; k >= 1; k--) begin
        if (rot[k]) begin
          days = WDAY_W'(k);
          ok   = 1'b1;
        end
      end
      if (!ok && rot[0]) begin
        days = DAYS_IN_WEEK;
        ok   = 1'b1;
      end
    end

    ev.hit     = entry_active && entry_valid && ok;
    ev.delta   = DELTA_W'(days) * DAY_MINUTES + DELTA_W'(tgt_tod) - DELTA_W'(now_tod);
    ev.weekday = weekday_add(wd, days);
    ev.hour    = eh;
    ev.minute  = em;
  end

endmodule

// ===== hw/rtl/waef_best_tracker.sv =====
// running minimum over a scan and the result register
// depends on waef_pkg and waef_result_if
`timescale 1ns / 1ps

module waef_best_tracker
  import waef_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  stage_t                stage,
  input  logic                  src,
  input  logic [INDEX_BITS-1:0] idx,
  input  eval_t                 ev,
  output logic                  adv,
  waef_result_if.source         results
);

  logic                  have_best;
  logic [DELTA_W-1:0]    best_delta;
  logic                  best_source;
  logic [INDEX_BITS-1:0] best_index;
  logic [WDAY_W-1:0]     best_weekday;
  logic [HOUR_W-1:0]     best_hour;
  logic [MIN_W-1:0]      best_minute;

  logic                  take;
  logic                  m_have;
  logic [DELTA_W-1:0]    m_delta;
  logic                  m_source;
  logic [INDEX_BITS-1:0] m_index;
  logic [WDAY_W-1:0]     m_weekday;
  logic [HOUR_W-1:0]     m_hour;
  logic [MIN_W-1:0]      m_minute;

  // ties go to the later entry
  always_comb begin
    take      = ev.hit && (!have_best || (ev.delta <= best_delta));
    m_have    = have_best || take;
    m_delta   = take ? ev.delta   : best_delta;
    m_source  = take ? src        : best_source;
    m_index   = take ? idx        : best_index;
    m_weekday = take ? ev.weekday : best_weekday;
    m_hour    = take ? ev.hour    : best_hour;
    m_minute  = take ? ev.minute  : best_minute;
  end

  assign adv = stage.valid && (!stage.last || !results.valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best     <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && !(adv && stage.last)) begin
        results.valid <= 1'b0;
      end
      if (adv) begin
        if (stage.last) begin
          have_best     <= 1'b0;
          results.valid <= 1'b1;
        end else begin
          have_best <= m_have;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take && !stage.last) begin
      best_delta   <= ev.delta;
      best_source  <= src;
      best_index   <= idx;
      best_weekday <= ev.weekday;
      best_hour    <= ev.hour;
      best_minute  <= ev.minute;
    end
    if (adv && stage.last) begin
      results.found         <= m_have;
      results.win_source    <= m_have ? m_source : 1'b0;
      results.win_index     <= m_have ? IDX_W'(m_index) : '0;
      results.next_weekday  <= m_have ? m_weekday : '0;
      results.next_hour     <= m_have ? m_hour : '0;
      results.next_minute   <= m_have ? m_minute : '0;
      results.delta_minutes <= m_have ? m_delta : '0;
    end
  end

endmodule

// ===== hw/rtl/weekly_alarm_earliest_finder.sv =====
// top level of the weekly alarm earliest finder: config registers, entry register
// depends on waef_pkg, waef_entry_if, waef_result_if, waef_entry_eval,
// waef_best_tracker and the assertion macro header
`timescale 1ns / 1ps
`include "weekly_alarm_earliest_finder_macros.svh"

// Scans alarm entries, one transaction per entry, and on the entry marked last
// delivers the entry that fires soonest after the current weekday, hour and
// minute held in the config registers (ties go to the later entry), with a
// found flag that is 0, and all other fields 0, when no entry qualified.
// An entry is taken every clock cycle unless intake stalls: it is captured in an
// input register, evaluated in combinational logic and folded into the running
// minimum; the result register loads as the last entry leaves the input register.
// Entry intake stalls only when a last entry reaches the evaluation stage while the
// previous result still waits in the result register. The user must write config
// through cfg_we / cfg_index / cfg_data while no scan is in flight (not enforced).
module weekly_alarm_earliest_finder
  import waef_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  waef_entry_if.sink             entries,
  waef_result_if.source          results
);

  logic [WDAY_W-1:0]     now_weekday;
  logic [HOUR_W-1:0]     now_hour;
  logic [MIN_W-1:0]      now_minute;

  stage_t                stage;
  logic [HOUR_W-1:0]     s_hour;
  logic [MIN_W-1:0]      s_minute;
  logic [MASK_W-1:0]     s_mask;
  logic                  s_active;
  logic                  s_valid;
  logic                  s_source;
  logic [INDEX_BITS-1:0] s_index;

  logic                  accept;
  logic                  adv;
  eval_t                 ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      now_weekday <= '0;
      now_hour    <= '0;
      now_minute  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WEEKDAY: now_weekday <= cfg_data[WDAY_W-1:0];
        CFG_HOUR:    now_hour    <= cfg_data[HOUR_W-1:0];
        CFG_MINUTE:  now_minute  <= cfg_data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign entries.ready = !stage.valid || adv;
  assign accept        = entries.valid && entries.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (accept) begin
      stage.valid <= 1'b1;
    end else if (adv) begin
      stage.valid <= 1'b0;
    end
    if (accept) begin
      stage.last <= entries.last_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_hour     <= entries.entry_hour;
      s_minute   <= entries.entry_minute;
      s_mask     <= entries.repeat_mask;
      s_active   <= entries.entry_active;
      s_valid    <= entries.entry_valid;
      s_source   <= entries.entry_source;
      s_index    <= entries.entry_index[INDEX_BITS-1:0];
    end
  end

  waef_entry_eval u_eval (
    .now_weekday  (now_weekday),
    .now_hour     (now_hour),
    .now_minute   (now_minute),
    .entry_hour   (s_hour),
    .entry_minute (s_minute),
    .repeat_mask  (s_mask),
    .entry_active (s_active),
    .entry_valid  (s_valid),
    .ev           (ev)
  );

  waef_best_tracker #(
    .INDEX_BITS (INDEX_BITS)
  ) u_tracker (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .src     (s_source),
    .idx     (s_index),
    .ev      (ev),
    .adv     (adv),
    .results (results)
  );

  // intake only stalls behind a waiting result
  `WAEF_ASSERT(a_stall_cause, clk, rst, !entries.ready |-> results.valid && stage.valid && stage.last)
  // a last entry leaving the stage always produces a result
  `WAEF_ASSERT(a_last_gives_result, clk, rst, adv && stage.last |=> results.valid)
  `WAEF_ASSERT(a_empty_scan_zero, clk, rst, results.valid && !results.found |-> results.delta_minutes == '0 && results.win_index == '0 && results.next_weekday == '0)
  `WAEF_ASSERT(a_result_range, clk, rst, results.valid && results.found |-> results.delta_minutes <= WEEK_MINUTES && results.next_weekday <= LAST_WEEKDAY)
  `WAEF_ASSERT_ALWAYS(a_reset_clears, clk, $past(rst) |-> !results.valid && !stage.valid)

endmodule
